FILE: design/pwmdim_pkg.sv
// Shared types and constants for the PWM dimmer with potentiometer deadband.
// Used by every module of the block; depends on nothing.
package pwmdim_pkg;

    // Field widths fixed by the command and result words
    localparam int unsigned SAMPLE_W  = 12;
    localparam int unsigned REQ_W     = 8;
    localparam int unsigned DUTY_W    = 8;
    localparam int unsigned PCT_W     = 7;

    // Full scale of a percentage and the saturated duty
    localparam int unsigned PCT_FULL  = 100;
    localparam int unsigned DUTY_SAT  = 255;

    // Parameter defaults
    localparam int unsigned DUTY_MAX_DEF = 255;
    localparam int unsigned ADC_MAX_DEF  = 4095;

    // Threshold after reset
    localparam logic [PCT_W-1:0] THRESH_RESET = 7'd5;

    // Command kinds
    typedef enum logic [1:0] {
        KIND_POT     = 2'd0,
        KIND_ENABLE  = 2'd1,
        KIND_PERCENT = 2'd2
    } kind_t;

    // Input word
    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] pot_sample;
        logic                enable_request;
        logic [REQ_W-1:0]    percent_request;
    } in_t;

    // Result word
    typedef struct packed {
        logic [DUTY_W-1:0] pwm_level;
        logic              output_enabled;
        logic [PCT_W-1:0]  value_percent;
    } out_t;

    // Scaled command passed from the scale stage to the state stage
    typedef struct packed {
        logic [1:0]       kind;
        logic [PCT_W-1:0] pot_pct;
        logic             enable_request;
        logic [PCT_W-1:0] req_pct;
    } mid_t;

endpackage

FILE: design/pwmdim_scale.sv
// Input register and percentage scaling stage of the PWM dimmer.
// Depends on pwmdim_pkg for the word types and field widths.
module pwmdim_scale #(
    parameter int unsigned ADC_MAX = pwmdim_pkg::ADC_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pwmdim_pkg::in_t   in_word,
    output logic              mid_valid,
    input  logic              mid_stall,
    output pwmdim_pkg::mid_t  mid_word
);

    // Reciprocal scaling: floor(100*s/ADC_MAX) == (s * 100 * RECIP) >> SHIFT
    localparam int unsigned SW      = pwmdim_pkg::SAMPLE_W;
    localparam int unsigned PW      = pwmdim_pkg::PCT_W;
    localparam longint unsigned NUM_MAX =
        longint'(pwmdim_pkg::PCT_FULL) * ((longint'(1) << SW) - 1);
    localparam int unsigned NUM_W   = $clog2(NUM_MAX + 1);
    localparam int unsigned LOG_D   = $clog2(ADC_MAX);
    localparam int unsigned SHIFT   = NUM_W + LOG_D;
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(ADC_MAX) - 1) / longint'(ADC_MAX);
    localparam longint unsigned COEF = longint'(pwmdim_pkg::PCT_FULL) * RECIP;
    localparam int unsigned COEF_W  = $clog2(COEF + 1);
    localparam int unsigned PROD_W  = SW + COEF_W;
    localparam int unsigned QW      = PROD_W - SHIFT;
    localparam int unsigned QX      = (QW > PW) ? QW : PW;

    pwmdim_pkg::in_t  in_reg;
    logic             in_valid_reg;
    pwmdim_pkg::mid_t mid_reg;
    logic             mid_valid_reg;

    logic              mid_free;
    logic              in_free;
    logic [PROD_W-1:0] prod;
    logic [QX-1:0]     quot;
    logic [PW-1:0]     pot_pct;
    logic [PW-1:0]     req_pct;

    // Stage readiness: a stage takes a word when empty or when its word moves on
    assign mid_free = !mid_valid_reg || !mid_stall;
    assign in_free  = !in_valid_reg || mid_free;
    assign in_stall = !in_free;

    // Scale the raw sample to a percentage, saturate at full scale
    assign prod = {{COEF_W{1'b0}}, in_reg.pot_sample} * {{SW{1'b0}}, COEF_W'(COEF)};
    assign quot = QX'(prod[PROD_W-1:SHIFT]);
    assign pot_pct = (quot > QX'(pwmdim_pkg::PCT_FULL)) ? PW'(pwmdim_pkg::PCT_FULL)
                                                         : quot[PW-1:0];

    // Clamp the requested percentage
    assign req_pct = (in_reg.percent_request > pwmdim_pkg::REQ_W'(pwmdim_pkg::PCT_FULL))
                   ? PW'(pwmdim_pkg::PCT_FULL) : in_reg.percent_request[PW-1:0];

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= in_valid;
            if (mid_free)
                mid_valid_reg <= in_valid_reg;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && in_free)
            in_reg <= in_word;
        if (in_valid_reg && mid_free)
        begin
            mid_reg.kind           <= in_reg.kind;
            mid_reg.pot_pct        <= pot_pct;
            mid_reg.enable_request <= in_reg.enable_request;
            mid_reg.req_pct        <= req_pct;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_word  = mid_reg;

endmodule

FILE: design/pwmdim_core.sv
// State stage of the PWM dimmer: duty, enable flag, last pot percentage
// and the result register. Depends on pwmdim_pkg for types and constants.
module pwmdim_core #(
    parameter int unsigned DUTY_MAX = pwmdim_pkg::DUTY_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pwmdim_pkg::PCT_W-1:0] threshold,
    input  logic                        mid_valid,
    output logic                        mid_stall,
    input  pwmdim_pkg::mid_t            mid_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pwmdim_pkg::out_t            out_word
);

    localparam int unsigned PW = pwmdim_pkg::PCT_W;
    localparam int unsigned DW = pwmdim_pkg::DUTY_W;
    localparam int unsigned NPCT = pwmdim_pkg::PCT_FULL + 1;

    // Duty and readback percent for each applied percentage
    logic [DW-1:0] duty_tab [NPCT];
    logic [PW-1:0] vp_tab   [NPCT];

    for (genvar k = 0; k < NPCT; k++)
    begin : g_tab
        localparam longint unsigned D0 = longint'(DUTY_MAX) * k / pwmdim_pkg::PCT_FULL;
        localparam longint unsigned DK = (D0 > pwmdim_pkg::DUTY_SAT) ?
                                         pwmdim_pkg::DUTY_SAT : D0;
        localparam longint unsigned V0 = DK * pwmdim_pkg::PCT_FULL / DUTY_MAX;
        localparam longint unsigned VK = (V0 > pwmdim_pkg::PCT_FULL) ?
                                         pwmdim_pkg::PCT_FULL : V0;
        assign duty_tab[k] = DW'(DK);
        assign vp_tab[k]   = PW'(VK);
    end

    logic [DW-1:0]    duty_reg, duty_next;
    logic [PW-1:0]    vp_reg, vp_next;
    logic             en_reg, en_next;
    logic [PW-1:0]    last_reg, last_next;
    logic             out_valid_reg;
    pwmdim_pkg::out_t out_reg;

    logic          take;
    logic [PW-1:0] diff;

    assign take      = mid_valid && (!out_valid_reg || !out_stall);
    assign mid_stall = out_valid_reg && out_stall;
    assign diff = (mid_word.pot_pct > last_reg) ? (mid_word.pot_pct - last_reg)
                                                : (last_reg - mid_word.pot_pct);

    // Apply the command to the state
    always_comb
    begin
        duty_next = duty_reg;
        vp_next   = vp_reg;
        en_next   = en_reg;
        last_next = last_reg;
        case (mid_word.kind)
            pwmdim_pkg::KIND_POT:
            begin
                if (diff > threshold)
                begin
                    duty_next = duty_tab[mid_word.pot_pct];
                    vp_next   = vp_tab[mid_word.pot_pct];
                    last_next = mid_word.pot_pct;
                    en_next   = (mid_word.pot_pct >= threshold);
                end
            end
            pwmdim_pkg::KIND_ENABLE:
            begin
                en_next = mid_word.enable_request;
            end
            pwmdim_pkg::KIND_PERCENT:
            begin
                duty_next = duty_tab[mid_word.req_pct];
                vp_next   = vp_tab[mid_word.req_pct];
                if (duty_tab[mid_word.req_pct] == '0)
                    en_next = 1'b0;
            end
            default:
            begin
                duty_next = duty_reg;
            end
        endcase
    end

    // Advance state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg      <= '0;
            vp_reg        <= '0;
            en_reg        <= 1'b0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                duty_reg <= duty_next;
                vp_reg   <= vp_next;
                en_reg   <= en_next;
                last_reg <= last_next;
            end
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= mid_valid;
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.pwm_level      <= en_next ? duty_next : '0;
            out_reg.output_enabled <= en_next;
            out_reg.value_percent  <= vp_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: design/pwm_dimmer_with_pot_deadband_unit.sv
// Top level of the PWM dimmer with potentiometer deadband.
// Depends on pwmdim_pkg, pwmdim_scale and pwmdim_core.
//
// Usage:
//   in_*  : command words (pot sample, enable, percentage), valid/stall.
//   out_* : one result word per command: PWM level, enable flag and duty
//           read back as percent, valid/stall.
//   cfg_* : writes the change threshold; cfg_ready is always high. Write it
//           only while no command is in flight.
// Timing: three register stages (input, scaled percentage, result). A word
//   taken moves from the input register to the scaled register, then to the
//   result register on out_word. One word per cycle is sustained while
//   out_stall is low; the scale multiplier and the state update each sit in their own stage.
// Reset: threshold returns to 5, duty, enable flag and last pot percent to
//   zero, all stages empty.
// Stall: a stalled result holds; the stages behind it keep filling until
//   each holds a word, then in_stall rises.
module pwm_dimmer_with_pot_deadband_unit #(
    parameter int unsigned DUTY_MAX = pwmdim_pkg::DUTY_MAX_DEF,
    parameter int unsigned ADC_MAX  = pwmdim_pkg::ADC_MAX_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  pwmdim_pkg::in_t              in_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output pwmdim_pkg::out_t             out_word,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pwmdim_pkg::PCT_W-1:0] cfg_data
);

    logic [pwmdim_pkg::PCT_W-1:0] thresh_reg;
    logic                         mid_valid;
    logic                         mid_stall;
    pwmdim_pkg::mid_t             mid_word;

    // Threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= pwmdim_pkg::THRESH_RESET;
        else if (cfg_valid && cfg_ready)
            thresh_reg <= cfg_data;
    end

    pwmdim_scale #(
        .ADC_MAX (ADC_MAX)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .mid_valid (mid_valid),
        .mid_stall (mid_stall),
        .mid_word  (mid_word)
    );

    pwmdim_core #(
        .DUTY_MAX (DUTY_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thresh_reg),
        .mid_valid (mid_valid),
        .mid_stall (mid_stall),
        .mid_word  (mid_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

FILE: design/pwmdim_checker.sv
// Port-level checks for the PWM dimmer, bound to the top level.
// Depends on pwmdim_pkg for the result word type.
module pwmdim_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input pwmdim_pkg::out_t out_word
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("result changed while stalled");

    // Drive no level while disabled
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.output_enabled |-> out_word.pwm_level == '0)
        else $error("pwm level nonzero while disabled");

    // Keep readback within full scale
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.value_percent <= pwmdim_pkg::PCT_W'(pwmdim_pkg::PCT_FULL))
        else $error("readback percent above full scale");

endmodule

bind pwm_dimmer_with_pot_deadband_unit pwmdim_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

FILE: tb/sv/tb.sv
// Self-checking bench for pwm_dimmer_with_pot_deadband_unit: directed table, then random
// command words over several threshold settings, checked against a local dimmer predictor.
// Depends on pwmdim_pkg and the RTL top level only.
module tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT    = 38;
    localparam int unsigned RAND_PHASE  = 100;
    localparam int unsigned SETTLE_MAX  = 5000;

    typedef struct {
        pwmdim_pkg::in_t  word;
        bit               known;
        pwmdim_pkg::out_t result;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pwmdim_pkg::in_t  in_word;
    logic out_valid;
    logic out_stall = 1'b0;
    pwmdim_pkg::out_t out_word;
    logic cfg_valid;
    logic cfg_ready;
    logic [pwmdim_pkg::PCT_W-1:0] cfg_data;

    // Predicted dimmer state
    logic [pwmdim_pkg::DUTY_W-1:0] duty_q;
    logic                          lamp_on_q;
    logic [pwmdim_pkg::PCT_W-1:0]  pot_pct_q;
    logic [pwmdim_pkg::PCT_W-1:0]  thresh_q;

    pwmdim_pkg::out_t dimmer_results_q[$];
    int   err_cnt = 0;
    bit   quiet   = 1'b0;

    // Directed commands, after reset with the default threshold
    dir_row_t dir_tab [19] = '{
        '{'{KIND_UNUSED,  12'hFFF, 1'b1, 8'hFF}, 1'b1, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_ENABLE,  12'h000, 1'b1, 8'h00}, 1'b1, '{8'd0,   1'b1, 7'd0}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'h000, 1'b0, 8'd100}, 1'b1, '{8'd255, 1'b1, 7'd100}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'hFFF, 1'b0, 8'd255}, 1'b1, '{8'd255, 1'b1, 7'd100}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'h000, 1'b1, 8'd0},   1'b1, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'h000, 1'b0, 8'd50},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_ENABLE,  12'hABC, 1'b1, 8'h00},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_ENABLE,  12'h000, 1'b0, 8'hFF},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_POT,     12'hFFF, 1'b0, 8'h00},  1'b1, '{8'd255, 1'b1, 7'd100}},
        '{'{pwmdim_pkg::KIND_POT,     12'd4000, 1'b0, 8'h00}, 1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_POT,     12'h000, 1'b1, 8'hFF},  1'b1, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_POT,     12'd205, 1'b0, 8'h00},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_POT,     12'd246, 1'b0, 8'h00},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{KIND_UNUSED,  12'h000, 1'b0, 8'h00},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'h000, 1'b0, 8'd1},   1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'h000, 1'b0, 8'd101}, 1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_POT,     12'd2048, 1'b0, 8'h00}, 1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_ENABLE,  12'h000, 1'b1, 8'h00},  1'b0, '{8'd0,   1'b0, 7'd0}},
        '{'{pwmdim_pkg::KIND_PERCENT, 12'h555, 1'b1, 8'h80},  1'b0, '{8'd0,   1'b0, 7'd0}}
    };

    pwm_dimmer_with_pot_deadband_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Advance the dimmer state by one command word and return its result word
    function automatic pwmdim_pkg::out_t dimmer_next(pwmdim_pkg::in_t w);
        int unsigned      pct;
        int unsigned      gap;
        int unsigned      d;
        int unsigned      vp;
        bit               apply;
        pwmdim_pkg::out_t r;
        apply = 1'b0;
        pct   = 0;
        if (w.kind == pwmdim_pkg::KIND_POT)
        begin
            pct = (pwmdim_pkg::PCT_FULL * 32'(w.pot_sample)) / pwmdim_pkg::ADC_MAX_DEF;
            if (pct > pwmdim_pkg::PCT_FULL)
                pct = pwmdim_pkg::PCT_FULL;
            gap = (pct > 32'(pot_pct_q)) ? pct - 32'(pot_pct_q) : 32'(pot_pct_q) - pct;
            apply = (gap > 32'(thresh_q));
        end
        else if (w.kind == pwmdim_pkg::KIND_ENABLE)
        begin
            lamp_on_q = w.enable_request;
        end
        else if (w.kind == pwmdim_pkg::KIND_PERCENT)
        begin
            pct   = 32'(w.percent_request);
            apply = 1'b1;
        end
        if (apply)
        begin
            if (pct > pwmdim_pkg::PCT_FULL)
                pct = pwmdim_pkg::PCT_FULL;
            d = (pwmdim_pkg::DUTY_MAX_DEF * pct) / pwmdim_pkg::PCT_FULL;
            if (d > pwmdim_pkg::DUTY_SAT)
                d = pwmdim_pkg::DUTY_SAT;
            duty_q = 8'(d);
            if (duty_q == '0)
                lamp_on_q = 1'b0;
            if (w.kind == pwmdim_pkg::KIND_POT)
            begin
                pot_pct_q = 7'(pct);
                lamp_on_q = (pct >= 32'(thresh_q));
            end
        end
        vp = (32'(duty_q) * pwmdim_pkg::PCT_FULL) / pwmdim_pkg::DUTY_MAX_DEF;
        if (vp > pwmdim_pkg::PCT_FULL)
            vp = pwmdim_pkg::PCT_FULL;
        r.pwm_level      = lamp_on_q ? duty_q : '0;
        r.output_enabled = lamp_on_q;
        r.value_percent  = 7'(vp);
        return r;
    endfunction

    // Offer one word from a falling edge; return at the falling edge after acceptance
    task automatic send_word(pwmdim_pkg::in_t w, bit known, pwmdim_pkg::out_t typed);
        pwmdim_pkg::out_t pred;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = dimmer_next(w);
        dimmer_results_q.push_back(known ? typed : pred);
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding result word, then let the pipe empty
    task automatic settle();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (dimmer_results_q.size() != 0 && n < SETTLE_MAX)
        begin
            @(negedge clk);
            n++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(logic [pwmdim_pkg::PCT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thresh_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic flag_mismatch(string field, int unsigned want, int unsigned got);
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        err_cnt++;
    endtask

    // Random receiver stall
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        pwmdim_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (dimmer_results_q.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, out_word);
                err_cnt++;
            end
            else
            begin
                want = dimmer_results_q.pop_front();
                if (out_word.pwm_level !== want.pwm_level)
                    flag_mismatch("pwm_level", 32'(want.pwm_level),
                                  32'(out_word.pwm_level));
                if (out_word.output_enabled !== want.output_enabled)
                    flag_mismatch("output_enabled", 32'(want.output_enabled),
                                  32'(out_word.output_enabled));
                if (out_word.value_percent !== want.value_percent)
                    flag_mismatch("value_percent", 32'(want.value_percent),
                                  32'(out_word.value_percent));
            end
        end
    end

    // Hard stop for a hung run
    initial
    begin
        #4000000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [pwmdim_pkg::PCT_W-1:0] thresh_plan [7];
        pwmdim_pkg::in_t              w;
        pwmdim_pkg::out_t             none;
        int                           tgt;
        int unsigned                  roll;
        int unsigned                  s;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        none      = '0;
        duty_q    = '0;
        lamp_on_q = 1'b0;
        pot_pct_q = '0;
        thresh_q  = pwmdim_pkg::THRESH_RESET;

        thresh_plan = '{pwmdim_pkg::THRESH_RESET, 7'd0, 7'd127, 7'd1, 7'd100,
                        7'($urandom_range(2, 30)), pwmdim_pkg::THRESH_RESET};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_tab[i])
            send_word(dir_tab[i].word, dir_tab[i].known, dir_tab[i].result);

        foreach (thresh_plan[ph])
        begin
            // Change the threshold only with the pipe empty
            if (ph != 0)
            begin
                settle();
                write_threshold(thresh_plan[ph]);
            end
            for (int i = 0; i < RAND_PHASE; i++)
            begin
                quiet = (ph == 3) && (i < 80);
                // Fill unused fields with noise
                w.pot_sample      = 12'($urandom);
                w.enable_request  = 1'($urandom);
                w.percent_request = 8'($urandom);
                roll = $urandom_range(99);
                if (roll < 45)
                begin
                    w.kind = pwmdim_pkg::KIND_POT;
                    case ($urandom_range(3))
                        0: ;
                        1:
                        begin
                            // Aim just around the deadband edge
                            tgt = int'(pot_pct_q) + ($urandom_range(1) ? 1 : -1)
                                  * (int'(thresh_q) + int'($urandom_range(2)) - 1);
                            if (tgt < 0)
                                tgt = 0;
                            if (tgt > int'(pwmdim_pkg::PCT_FULL))
                                tgt = int'(pwmdim_pkg::PCT_FULL);
                            s = (32'(tgt) * pwmdim_pkg::ADC_MAX_DEF) / pwmdim_pkg::PCT_FULL
                                + $urandom_range(40);
                            w.pot_sample = (s > pwmdim_pkg::ADC_MAX_DEF) ? 12'hFFF : 12'(s);
                        end
                        2: w.pot_sample = $urandom_range(1) ? 12'hFFF : 12'h000;
                        default: w.pot_sample = 12'($urandom_range(300));
                    endcase
                end
                else if (roll < 75)
                begin
                    w.kind = pwmdim_pkg::KIND_PERCENT;
                    case ($urandom_range(2))
                        0: ;
                        1: w.percent_request = 8'($urandom_range(100));
                        default: w.percent_request = $urandom_range(1) ? 8'd255 : 8'd0;
                    endcase
                end
                else if (roll < 93)
                begin
                    w.kind = pwmdim_pkg::KIND_ENABLE;
                end
                else
                begin
                    w.kind = KIND_UNUSED;
                end
                send_word(w, 1'b0, none);
            end
            quiet = 1'b0;
        end

        settle();
        if (dimmer_results_q.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, dimmer_results_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
